@@ src/h264_slice_type_detector_assert.svh @@
// Assertion macros for the slice type detector.
`ifndef H264_SLICE_TYPE_DETECTOR_ASSERT_SVH
`define H264_SLICE_TYPE_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define SLTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define SLTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/sltd_pkg.sv @@
`timescale 1ns / 1ps
package sltd_pkg;

  // Most leading zeros an Exp-Golomb code may carry.
  localparam logic [4:0] MAX_ZEROS = 5'd24;

  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_FIRST  = 3'd2;
  localparam logic [2:0] PH_SECOND = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  localparam logic [2:0] RES_P   = 3'd0;
  localparam logic [2:0] RES_B   = 3'd1;
  localparam logic [2:0] RES_I   = 3'd2;
  localparam logic [2:0] RES_IDR = 3'd3;
  localparam logic [2:0] RES_ERR = 3'd4;

  localparam logic [1:0] CAUSE_NONE     = 2'd0;
  localparam logic [1:0] CAUSE_NO_SLICE = 2'd1;
  localparam logic [1:0] CAUSE_TYPE     = 2'd2;
  localparam logic [1:0] CAUSE_CODE     = 2'd3;

  localparam logic [4:0] NAL_NON_IDR = 5'd1;
  localparam logic [4:0] NAL_IDR     = 5'd5;

  typedef struct packed {
    logic [2:0] phase;
    logic [4:0] zero_run;
    logic [4:0] bits_left;
    logic [4:0] type_value;
  } sltd_eg_t;

  typedef struct packed {
    logic       have;
    logic [2:0] kind;
    logic [1:0] cause;
  } sltd_res_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] fill;
  } sltd_stat_t;

endpackage

@@ src/sltd_eg_byte.sv @@
`timescale 1ns / 1ps
module sltd_eg_byte #(
  parameter logic [4:0] MAX_ZEROS = sltd_pkg::MAX_ZEROS
) (
  input  sltd_pkg::sltd_eg_t  cur,
  input  logic [7:0]          data_byte,
  output sltd_pkg::sltd_eg_t  nxt,
  output sltd_pkg::sltd_res_t res
);
  import sltd_pkg::*;

  // Walks the eight bits MSB first through the Exp-Golomb decoder.
  always_comb begin
    logic [2:0] ph;
    logic [4:0] zr;
    logic [4:0] bl;
    logic [4:0] tv;
    logic [4:0] t;
    logic       b;
    logic       done;
    ph = cur.phase;
    zr = cur.zero_run;
    bl = cur.bits_left;
    tv = cur.type_value;
    t = '0;
    b = 1'b0;
    done = 1'b0;
    res = '0;
    for (int k = 7; k >= 0; k--) begin
      if (ph == PH_FIRST || ph == PH_SECOND) begin
        b = data_byte[k];
        done = 1'b0;
        if (bl == 5'd0) begin
          if (!b) begin
            if (zr >= MAX_ZEROS) begin
              res = '{have: 1'b1, kind: RES_ERR, cause: CAUSE_CODE};
              ph = PH_DONE;
            end else begin
              zr = zr + 5'd1;
            end
          end else begin
            tv = 5'd1;
            bl = zr;
            done = (zr == 5'd0);
          end
        end else begin
          tv = (tv >= 5'd16) ? 5'd31 : {tv[3:0], b};
          bl = bl - 5'd1;
          done = (bl == 5'd0);
        end
        if (done) begin
          if (ph == PH_FIRST) begin
            ph = PH_SECOND;
            zr = '0;
            bl = '0;
            tv = '0;
          end else begin
            t = tv - 5'd1;
            if (t > 5'd4) begin
              t = t - 5'd5;
            end
            if (t <= 5'd2) begin
              res = '{have: 1'b1, kind: t[2:0], cause: CAUSE_NONE};
            end else begin
              res = '{have: 1'b1, kind: RES_ERR, cause: CAUSE_TYPE};
            end
            ph = PH_DONE;
          end
        end
      end
    end
    nxt = '{phase: ph, zero_run: zr, bits_left: bl, type_value: tv};
  end

endmodule

@@ src/sltd_parser.sv @@
`timescale 1ns / 1ps
module sltd_parser #(
  parameter logic [4:0] MAX_ZEROS = sltd_pkg::MAX_ZEROS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output sltd_pkg::sltd_res_t res,
  output sltd_pkg::sltd_stat_t stat
);
  import sltd_pkg::*;

  logic [15:0] window_r, window_nxt;
  logic [1:0]  fill_r, fill_nxt;
  sltd_eg_t    eg_r, eg_nxt;
  sltd_eg_t    eg_byte_nxt;
  sltd_res_t   eg_res;

  sltd_eg_byte #(
    .MAX_ZEROS (MAX_ZEROS)
  ) u_eg_byte (
    .cur       (eg_r),
    .data_byte (data_byte),
    .nxt       (eg_byte_nxt),
    .res       (eg_res)
  );

  always_comb begin
    window_nxt = window_r;
    fill_nxt = fill_r;
    eg_nxt = eg_r;
    res = '0;
    case (eg_r.phase)
      PH_SEARCH: begin
        if (fill_r == 2'd2 && window_r == 16'd0 && data_byte == 8'd1) begin
          eg_nxt.phase = PH_HEADER;
        end
        window_nxt = {window_r[7:0], data_byte};
        if (fill_r < 2'd2) begin
          fill_nxt = fill_r + 2'd1;
        end
      end
      PH_HEADER: begin
        if (data_byte[4:0] == NAL_IDR) begin
          res = '{have: 1'b1, kind: RES_IDR, cause: CAUSE_NONE};
          eg_nxt.phase = PH_DONE;
        end else if (data_byte[4:0] == NAL_NON_IDR) begin
          eg_nxt = '{phase: PH_FIRST, zero_run: '0, bits_left: '0, type_value: '0};
        end else begin
          eg_nxt.phase = PH_SEARCH;
          window_nxt = {window_r[7:0], data_byte};
          fill_nxt = 2'd2;
        end
      end
      PH_FIRST, PH_SECOND: begin
        eg_nxt = eg_byte_nxt;
        res = eg_res;
      end
      PH_DONE: begin
      end
      default: begin
        eg_nxt.phase = PH_DONE;
      end
    endcase
    if (last_byte) begin
      if (!res.have) begin
        if (eg_nxt.phase == PH_SEARCH || eg_nxt.phase == PH_HEADER) begin
          res = '{have: 1'b1, kind: RES_ERR, cause: CAUSE_NO_SLICE};
        end else if (eg_nxt.phase == PH_FIRST || eg_nxt.phase == PH_SECOND) begin
          res = '{have: 1'b1, kind: RES_ERR, cause: CAUSE_CODE};
        end
      end
      window_nxt = '0;
      fill_nxt = '0;
      eg_nxt = '{phase: PH_SEARCH, zero_run: '0, bits_left: '0, type_value: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      fill_r <= '0;
      eg_r <= '{phase: PH_SEARCH, zero_run: '0, bits_left: '0, type_value: '0};
    end else if (step_en) begin
      window_r <= window_nxt;
      fill_r <= fill_nxt;
      eg_r <= eg_nxt;
    end
  end

  assign stat = '{phase: eg_r.phase, fill: fill_r};

endmodule

@@ src/h264_slice_type_detector.sv @@
// H.264 slice type detector. Bytes of one buffer enter one per cycle, the final byte
// flagged by in_last_byte; the block finds a 00 00 01 start code with a NAL header of
// type 1 or 5 and returns exactly one transaction per buffer: P, B, I or IDR, or an
// error with its cause (no slice found, SP/SI or out-of-range type, or an Exp-Golomb
// code cut off by the buffer end or longer than MAX_ZEROS leading zeros). The result
// leaves on the byte that decides it, or on the last byte at the latest; bytes after
// a decision are consumed without output. Emulation-prevention bytes are not removed.
// A byte is accepted every cycle while in_stall is low; it passes the input register and the
// eight-bit Exp-Golomb step, and its result is held in the result register. in_stall rises
// only while a byte waits and the result register is held by out_stall.
`timescale 1ns / 1ps
`include "h264_slice_type_detector_assert.svh"
module h264_slice_type_detector #(
  parameter logic [4:0] MAX_ZEROS = sltd_pkg::MAX_ZEROS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_slice_result,
  output logic [1:0] out_error_cause
);
  import sltd_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;
  logic       step_en;
  logic       out_valid_r;
  logic [2:0] out_result_r;
  logic [1:0] out_cause_r;
  sltd_res_t  res;
  sltd_stat_t stat;

  assign step_en = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (step_en) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  sltd_parser #(
    .MAX_ZEROS (MAX_ZEROS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .data_byte (s1_data_r),
    .last_byte (s1_last_r),
    .res       (res),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= res.have;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res.have) begin
      out_result_r <= res.kind;
      out_cause_r <= res.cause;
    end
  end

  assign out_valid = out_valid_r;
  assign out_slice_result = out_result_r;
  assign out_error_cause = out_cause_r;

  `SLTD_ASSERT_NOW(a_cause_matches_kind, out_valid, (out_slice_result == RES_ERR) == (out_error_cause != CAUSE_NONE), "error cause does not match result kind")
  `SLTD_ASSERT_NOW(a_kind_range, out_valid, out_slice_result <= RES_ERR, "result kind out of range")
  `SLTD_ASSERT_NEXT(a_rearm_after_last, step_en && s1_last_r, stat.phase == PH_SEARCH && stat.fill == 2'd0, "parser not re-armed after last byte")
  `SLTD_ASSERT_NOW(a_stall_cause, in_stall, s1_valid_r && out_valid_r && out_stall, "input stalled without a blocked result")

endmodule
